>>> rtl/core/srsw_pkg.sv
// Package: shared types, constants and codes of the send window tracker.
package srsw_pkg;
	localparam int DEF_MAX_SLOTS = 16;
	localparam int SEQ_W = 31;
	localparam int TIME_W = 32;
	localparam int WIN_W = 5;
	localparam int TMO_W = 16;
	localparam int CFG_W = 16;
	localparam logic [4:0] WIN_RESET = 5'd8;
	localparam logic [15:0] TMO_RESET = 16'd5000;
	localparam logic CFG_WINDOW = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		MODE_SEND = 2'd0,
		MODE_ACK  = 2'd1,
		MODE_TICK = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		K_GRANT   = 3'd0,
		K_REFUSE  = 3'd1,
		K_ACK     = 3'd2,
		K_RETX    = 3'd3,
		K_NOTHING = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACK_FIND,
		ST_SLIDE,
		ST_ACK_OUT,
		ST_TICK,
		ST_TICK_END
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input item
		logic do_send;   // grant or refuse, emit
		logic ack_step;  // examine slot at scan index for the ack
		logic slide_step;// free slot at scan index if it holds the base
		logic scan_rst;  // scan index to zero
		logic tick_step; // examine slot at scan index for timeout
		logic emit_ack;
		logic emit_none;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic slide_go;   // target equals base
		logic slide_hit;  // a slot holding base was freed this cycle
		logic any_retx;
	} stat_t;
endpackage

>>> rtl/core/srsw_ctrl.sv
// Controller: sequences one item through the slot scans.
module srsw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       mode,
	input  srsw_pkg::stat_t  st,
	output logic             busy,
	output srsw_pkg::cmd_t   cmd
);
	import srsw_pkg::*;
	state_t state_q, state_d;
	logic   hit_q; // slide pass found a slot

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != ST_SLIDE) hit_q <= 1'b0;
			else if (st.scan_last) hit_q <= 1'b0;
			else if (st.slide_hit) hit_q <= 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (mode_t'(mode))
						MODE_ACK:  state_d = ST_ACK_FIND;
						MODE_TICK: state_d = ST_TICK;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_ACK_FIND: if (st.scan_last) state_d = st.slide_go ? ST_SLIDE : ST_ACK_OUT;
			ST_SLIDE: begin
				// one pass over the slots; repeat while any slot was freed
				if (st.scan_last && !(hit_q || st.slide_hit)) state_d = ST_ACK_OUT;
			end
			ST_ACK_OUT: state_d = ST_IDLE;
			ST_TICK: if (st.scan_last) state_d = ST_TICK_END;
			ST_TICK_END: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
				cmd.scan_rst = 1'b1;
				cmd.do_send = start && (mode_t'(mode) == MODE_SEND);
			end
			ST_ACK_FIND: begin
				cmd.ack_step = 1'b1;
				cmd.scan_rst = st.scan_last;
			end
			ST_SLIDE: begin
				cmd.slide_step = 1'b1;
				cmd.scan_rst = st.scan_last;
			end
			ST_ACK_OUT: cmd.emit_ack = 1'b1;
			ST_TICK: cmd.tick_step = 1'b1;
			ST_TICK_END: cmd.emit_none = !st.any_retx;
			default: ;
		endcase
	end
endmodule

>>> rtl/core/srsw_dp.sv
// Datapath: slot store, window counters, result registers.
module srsw_dp #(
	parameter int MAX_SLOTS = srsw_pkg::DEF_MAX_SLOTS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  srsw_pkg::cmd_t            cmd,
	input  logic [30:0]               ack_number,
	input  logic [31:0]               time_now_ms,
	input  logic                      cfg_we,
	input  logic                      cfg_idx,
	input  logic [15:0]               cfg_wdata,
	output srsw_pkg::stat_t           st,
	output logic                      done,
	output logic [2:0]                kind,
	output logic [30:0]               seq_number,
	output logic [31:0]               rtt_ms,
	output logic                      rtt_valid,
	output logic [30:0]               base_seq,
	output logic [4:0]                in_flight,
	output logic                      all_acked,
	output logic                      last
);
	import srsw_pkg::*;
	localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SLOTS - 1);

	logic [MAX_SLOTS-1:0] valid_q, acked_q;
	logic [SEQ_W-1:0]  seq_q  [MAX_SLOTS];
	logic [TIME_W-1:0] sent_q [MAX_SLOTS];
	logic [SEQ_W-1:0]  base_q, next_q, target_q;
	logic [CW-1:0]     flight_q;
	logic [TIME_W-1:0] now_q, rtt_q;
	logic              found_q, any_q, last_slot_q;
	logic [IW-1:0]     idx_q;
	logic [WIN_W-1:0]  win_q;
	logic [TMO_W-1:0]  tmo_q;
	logic              ovalid_q;
	logic [2:0]        okind_q;
	logic [SEQ_W-1:0]  oseq_q, obase_q;
	logic [TIME_W-1:0] ortt_q;
	logic              orv_q, olast_q, oall_q;
	logic [4:0]        oflt_q;

	// combinational views of current slot
	logic [SEQ_W-1:0]  cur_seq;
	logic [TIME_W-1:0] age;
	logic              cur_v, cur_a, pending_after;
	logic [MAX_SLOTS-1:0] v_n, a_n;
	logic [IW-1:0]     free_idx;
	logic              free_ok;
	logic [CW-1:0]     win_sat;
	logic              retx_now, slide_now;

	assign cur_seq = seq_q[idx_q];
	assign cur_v = valid_q[idx_q];
	assign cur_a = acked_q[idx_q];
	assign age = now_q - sent_q[idx_q];
	assign st.scan_last = (idx_q == LAST_IDX);
	assign st.slide_go = (target_q == base_q);
	assign slide_now = cmd.slide_step && cur_v && cur_a && (cur_seq == base_q);
	assign st.slide_hit = slide_now;
	assign st.any_retx = any_q;
	assign retx_now = cmd.tick_step && cur_v && !cur_a && (age > TIME_W'(tmo_q));

	always_comb begin
		free_idx = '0;
		free_ok = 1'b0;
		for (int i = MAX_SLOTS - 1; i >= 0; i--)
			if (!valid_q[i]) begin
				free_idx = IW'(i);
				free_ok = 1'b1;
			end
		if (win_q > WIN_W'(MAX_SLOTS > 31 ? 31 : MAX_SLOTS)
				&& MAX_SLOTS <= 31)
			win_sat = CW'(MAX_SLOTS);
		else
			win_sat = CW'(win_q);
	end

	logic grant;
	assign grant = free_ok && ({1'b0, flight_q} < {1'b0, win_sat});

	always_comb begin
		v_n = valid_q;
		a_n = acked_q;
		if (cmd.do_send && grant) begin
			v_n[free_idx] = 1'b1;
			a_n[free_idx] = 1'b0;
		end
		if (cmd.ack_step && cur_v && !found_q && cur_seq == target_q) a_n[idx_q] = 1'b1;
		if (slide_now) begin
			v_n[idx_q] = 1'b0;
			a_n[idx_q] = 1'b0;
		end
		pending_after = |(v_n & ~a_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			acked_q <= '0;
			base_q <= '0;
			next_q <= '0;
			flight_q <= '0;
			rtt_q <= '0;
			idx_q <= '0;
			win_q <= WIN_RESET;
			tmo_q <= TMO_RESET;
			ovalid_q <= 1'b0;
			found_q <= 1'b0;
			any_q <= 1'b0;
		end else begin
			valid_q <= v_n;
			acked_q <= a_n;
			ovalid_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_idx == CFG_WINDOW) win_q <= cfg_wdata[WIN_W-1:0];
				else tmo_q <= cfg_wdata;
			end
			if (cmd.scan_rst) idx_q <= '0;
			else if (cmd.ack_step || cmd.slide_step || cmd.tick_step) idx_q <= idx_q + 1'b1;
			if (cmd.load) begin
				found_q <= 1'b0;
				any_q <= 1'b0;
			end
			if (cmd.do_send) begin
				ovalid_q <= 1'b1;
				okind_q <= grant ? K_GRANT : K_REFUSE;
				oseq_q <= next_q;
				ortt_q <= '0;
				orv_q <= 1'b0;
				olast_q <= 1'b1;
				if (grant) begin
					seq_q[free_idx] <= next_q;
					sent_q[free_idx] <= time_now_ms;
					next_q <= next_q + 1'b1;
					flight_q <= flight_q + 1'b1;
				end
				obase_q <= base_q;
				oflt_q <= grant ? 5'(flight_q + 1'b1) : 5'(flight_q);
				oall_q <= !pending_after;
			end
			if (cmd.ack_step && cur_v && !found_q && cur_seq == target_q) begin
				found_q <= 1'b1;
				rtt_q <= age;
			end
			if (slide_now) begin
				base_q <= base_q + 1'b1;
				if (flight_q != '0) flight_q <= flight_q - 1'b1;
			end
			if (cmd.emit_ack) begin
				ovalid_q <= 1'b1;
				okind_q <= K_ACK;
				oseq_q <= target_q;
				ortt_q <= found_q ? rtt_q : '0;
				orv_q <= found_q;
				olast_q <= 1'b1;
				obase_q <= base_q;
				oflt_q <= 5'(flight_q);
				oall_q <= !pending_after;
			end
			if (cmd.tick_step) begin
				// hold a due retransmit until the next is found, to mark the final one
				if (retx_now) begin
					sent_q[idx_q] <= now_q;
					if (any_q) begin
						ovalid_q <= 1'b1;
						okind_q <= K_RETX;
						oseq_q <= target_q;
						olast_q <= 1'b0;
					end
					any_q <= 1'b1;
					target_q <= cur_seq;
				end
			end
			if (cmd.load) begin
				target_q <= ack_number - 1'b1;
				now_q <= time_now_ms;
			end
			if (cmd.emit_none || last_slot_q) begin
				ovalid_q <= 1'b1;
				okind_q <= cmd.emit_none ? K_NOTHING : K_RETX;
				oseq_q <= cmd.emit_none ? '0 : target_q;
				olast_q <= 1'b1;
			end
			if (cmd.tick_step || cmd.emit_none || last_slot_q) begin
				ortt_q <= '0;
				orv_q <= 1'b0;
				obase_q <= base_q;
				oflt_q <= 5'(flight_q);
				oall_q <= !pending_after;
			end
		end
	end

	// final held retransmit: last_slot_q flags it as the scan ends, then the result registers send it out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) last_slot_q <= 1'b0;
		else last_slot_q <= cmd.tick_step && st.scan_last && (any_q || retx_now);
	end

	assign done = ovalid_q;
	assign kind = okind_q;
	assign seq_number = oseq_q;
	assign rtt_ms = ortt_q;
	assign rtt_valid = orv_q;
	assign base_seq = obase_q;
	assign in_flight = oflt_q;
	assign all_acked = oall_q;
	assign last = olast_q;
endmodule

>>> rtl/core/selective_repeat_send_window_top.sv
// Top level of the selective-repeat send window tracker.
// Usage:
//   Present mode, ack_number and time_now_ms with start while busy is low;
//   the item is taken at that edge. Results appear for one cycle each with
//   done high; last marks the final result of the item. The receiver
//   cannot stall, so results are never held back.
// Item handling (one item at a time):
//   send request: 1 result, in the cycle after accept; busy never rises.
//   ack: a match pass over all slots, then, when the acked sequence is the
//   base, slide passes over all slots, repeated until a pass frees nothing
//   (at most MAX_SLOTS+1 passes), then the result is emitted.
//   tick: one scan over all slots; retransmits stream out during the
//   scan, each in the cycle after the next due slot is found, and the
//   final result follows once the scan ends.
//   unknown mode: dropped, no result.
// Configuration: write cfg_we/cfg_idx/cfg_wdata while idle; index 0 is the
//   window length, 1 is timeout_ms.
// Reset: arst_n clears all slots, base, next sequence and counters, and
//   restores window 8 and timeout 5000.
module selective_repeat_send_window_top #(
	parameter int MAX_SLOTS = srsw_pkg::DEF_MAX_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [30:0] ack_number,
	input  logic [31:0] time_now_ms,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_wdata,
	output logic        done,
	output logic [2:0]  kind,
	output logic [30:0] seq_number,
	output logic [31:0] rtt_ms,
	output logic        rtt_valid,
	output logic [30:0] base_seq,
	output logic [4:0]  in_flight,
	output logic        all_acked,
	output logic        last
);
	import srsw_pkg::*;
	cmd_t  cmd;
	stat_t st;

	srsw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .mode(mode),
		.st(st), .busy(busy), .cmd(cmd)
	);

	srsw_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.ack_number(ack_number), .time_now_ms(time_now_ms),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.st(st), .done(done), .kind(kind), .seq_number(seq_number),
		.rtt_ms(rtt_ms), .rtt_valid(rtt_valid), .base_seq(base_seq),
		.in_flight(in_flight), .all_acked(all_acked), .last(last)
	);

	// in_flight never exceeds the slot count
	a_flight_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> in_flight <= 5'(MAX_SLOTS > 31 ? 31 : MAX_SLOTS))
		else $error("in_flight beyond slot count");
	// a send request never raises busy
	a_send_nobusy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_SEND) |=> !busy)
		else $error("send request stalled");
	// an accepted send yields a result next cycle
	a_send_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_SEND) |=> (done && last))
		else $error("send result missing");
endmodule

>>> sim/srsw_checker.sv
// Checker: predicts send window results from accepted items and compares them.
`timescale 1ns / 100ps
module srsw_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  mode,
	input  logic [30:0] ack_number,
	input  logic [31:0] time_now_ms,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_wdata,
	input  logic        done,
	input  logic [2:0]  kind,
	input  logic [30:0] seq_number,
	input  logic [31:0] rtt_ms,
	input  logic        rtt_valid,
	input  logic [30:0] base_seq,
	input  logic [4:0]  in_flight,
	input  logic        all_acked,
	input  logic        last,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);
	import srsw_pkg::*;
	localparam int SLOTS = DEF_MAX_SLOTS;

	typedef struct packed {
		kind_t       kind;
		logic [30:0] seq;
		logic [31:0] rtt;
		logic        rv;
		logic [30:0] base;
		logic [4:0]  flight;
		logic        all_acked;
		logic        last;
	} window_result_t;

	window_result_t expected_results[$];

	logic [4:0]  win_cfg;
	logic [15:0] tmo_cfg;
	logic        s_valid [SLOTS];
	logic        s_acked [SLOTS];
	logic [30:0] s_seq   [SLOTS];
	logic [31:0] s_time  [SLOTS];
	logic [30:0] base_q, next_q;
	logic [4:0]  flight_q;

	function automatic logic nothing_outstanding();
		for (int i = 0; i < SLOTS; i++)
			if (s_valid[i] && !s_acked[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic window_result_t make_result(kind_t k, logic [30:0] sq,
			logic [31:0] rt, logic rv);
		window_result_t r;
		r.kind = k;
		r.seq = sq;
		r.rtt = rt;
		r.rv = rv;
		r.base = base_q;
		r.flight = flight_q;
		r.all_acked = nothing_outstanding();
		r.last = 1'b0;
		return r;
	endfunction

	task automatic predict_window(logic [1:0] md, logic [30:0] ackn, logic [31:0] now);
		window_result_t batch[$];
		logic [4:0]  win;
		int          free_slot;
		int          hit;
		logic [30:0] target;
		logic [31:0] rtt;
		logic        rv;
		case (md)
			MODE_SEND: begin
				win = (win_cfg > SLOTS) ? 5'(SLOTS) : win_cfg;
				free_slot = -1;
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!s_valid[i])
						free_slot = i;
				if (flight_q < win && free_slot >= 0) begin
					s_valid[free_slot] = 1'b1;
					s_acked[free_slot] = 1'b0;
					s_seq[free_slot] = next_q;
					s_time[free_slot] = now;
					next_q = next_q + 31'd1;
					flight_q = flight_q + 5'd1;
					batch.insert(batch.size(),
						make_result(K_GRANT, next_q - 31'd1, '0, 1'b0));
				end else begin
					batch.insert(batch.size(), make_result(K_REFUSE, next_q, '0, 1'b0));
				end
			end
			MODE_ACK: begin
				target = ackn - 31'd1;
				rtt = '0;
				rv = 1'b0;
				for (int i = 0; i < SLOTS; i++)
					if (!rv && s_valid[i] && s_seq[i] == target) begin
						rtt = now - s_time[i];
						s_acked[i] = 1'b1;
						rv = 1'b1;
					end
				if (target == base_q) begin
					for (int st = 0; st < SLOTS; st++) begin
						hit = -1;
						for (int i = SLOTS - 1; i >= 0; i--)
							if (s_valid[i] && s_acked[i] && s_seq[i] == base_q)
								hit = i;
						if (hit < 0)
							break;
						s_valid[hit] = 1'b0;
						s_acked[hit] = 1'b0;
						base_q = base_q + 31'd1;
						if (flight_q > 0)
							flight_q = flight_q - 5'd1;
					end
				end
				batch.insert(batch.size(), make_result(K_ACK, target, rtt, rv));
			end
			MODE_TICK: begin
				for (int i = 0; i < SLOTS; i++)
					if (s_valid[i] && !s_acked[i] && (now - s_time[i]) > 32'(tmo_cfg)) begin
						s_time[i] = now;
						batch.insert(batch.size(), make_result(K_RETX, s_seq[i], '0, 1'b0));
					end
				if (batch.size() == 0)
					batch.insert(batch.size(), make_result(K_NOTHING, '0, '0, 1'b0));
				// all_acked and in_flight reflect the state after the whole scan
				foreach (batch[k]) begin
					batch[k].flight = flight_q;
					batch[k].all_acked = nothing_outstanding();
				end
			end
			default: ;
		endcase
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k])
			expected_results.insert(expected_results.size(), batch[k]);
	endtask

	task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		window_result_t exp_r;
		if (!arst_n) begin
			win_cfg <= WIN_RESET;
			tmo_cfg <= TMO_RESET;
			for (int i = 0; i < SLOTS; i++) begin
				s_valid[i] = 1'b0;
				s_acked[i] = 1'b0;
				s_seq[i] = '0;
				s_time[i] = '0;
			end
			base_q = '0;
			next_q = '0;
			flight_q = '0;
			fail_count = 0;
			results_seen <= 0;
			expected_results.delete();
		end else begin
			// compare before predicting, so a result and a new item on one edge keep order
			if (done) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("unexpected result: kind %0d seq %0d", kind, seq_number);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					compare_field("kind", 32'(exp_r.kind), 32'(kind));
					compare_field("seq_number", 32'(exp_r.seq), 32'(seq_number));
					compare_field("rtt_ms", exp_r.rtt, rtt_ms);
					compare_field("rtt_valid", 32'(exp_r.rv), 32'(rtt_valid));
					compare_field("base_seq", 32'(exp_r.base), 32'(base_seq));
					compare_field("in_flight", 32'(exp_r.flight), 32'(in_flight));
					compare_field("all_acked", 32'(exp_r.all_acked), 32'(all_acked));
					compare_field("last", 32'(exp_r.last), 32'(last));
				end
			end
			if (cfg_we) begin
				if (cfg_idx == CFG_WINDOW)
					win_cfg <= cfg_wdata[4:0];
				else
					tmo_cfg <= cfg_wdata;
			end
			if (start && !busy)
				predict_window(mode, ack_number, time_now_ms);
		end
	end

	assign pending = expected_results.size();
endmodule

>>> sim/testbench.sv
// Testbench top: drives items and configuration into the send window tracker.
`timescale 1ns / 100ps
module testbench;
	import srsw_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 125;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  mode = MODE_SEND;
	logic [30:0] ack_number = '0;
	logic [31:0] time_now_ms = '0;
	logic        cfg_we = 1'b0;
	logic        cfg_idx = CFG_WINDOW;
	logic [15:0] cfg_wdata = '0;
	logic        done;
	logic [2:0]  kind;
	logic [30:0] seq_number;
	logic [31:0] rtt_ms;
	logic        rtt_valid;
	logic [30:0] base_seq;
	logic [4:0]  in_flight;
	logic        all_acked;
	logic        last;
	int          fail_count;
	int          pending;
	int          results_seen;
	int          idle_cycles = 0;
	int          items_sent = 0;
	logic        timed_out = 1'b0;

	// Track the window base so acks aim at live sequences.
	logic [30:0] granted_lo = '0;
	logic [31:0] clock_ms = 32'd100;

	always #1 clk = ~clk;

	selective_repeat_send_window_top dut (.*);

	srsw_checker checker_i (.*);

	// Watchdog: count cycles without any accepted item, result or configuration write.
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out <= 1'b1;
			$display("watchdog expired with %0d results outstanding", pending);
			$display("selective_repeat_send_window_top verification failed");
			$finish;
		end
	end

	// Drop start and hold idle for a random gap: mostly short, now and then long.
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Present one item and hold it until the block takes it; start stays high
	// afterwards so a following item can go out back to back.
	task automatic issue_item(logic [1:0] md, logic [30:0] ackn, logic [31:0] now);
		logic took;
		start <= 1'b1;
		mode <= md;
		ack_number <= ackn;
		time_now_ms <= now;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end
		items_sent++;
	endtask

	// Drain all expected results, then let the block settle before a register write.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (2 * DEF_MAX_SLOTS + 8) @(posedge clk);
	endtask

	// Write the window length, then the timeout, on consecutive edges.
	task automatic write_cfg(logic [15:0] win, logic [15:0] tmo);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_WINDOW;
		cfg_wdata <= win;
		@(posedge clk);
		cfg_idx <= CFG_TIMEOUT;
		cfg_wdata <= tmo;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Pick a well-formed item most of the time: sends, acks near the base, ticks.
	task automatic random_item();
		int pick;
		logic [30:0] ackn;
		pick = $urandom_range(0, 99);
		clock_ms = clock_ms + $urandom_range(0, 3000);
		if (pick < 40) begin
			issue_item(MODE_SEND, 31'($urandom), clock_ms);
		end else if (pick < 75) begin
			ackn = granted_lo + 31'($urandom_range(1, 12));
			issue_item(MODE_ACK, ackn, clock_ms);
		end else if (pick < 92) begin
			issue_item(MODE_TICK, 31'($urandom), clock_ms);
		end else if (pick < 96) begin
			// noise: arbitrary ack and time, full field range
			issue_item(MODE_ACK, 31'($urandom), $urandom);
		end else begin
			// ignored item; do not count toward the stimulus
			issue_item(MODE_NONE, 31'($urandom), $urandom);
			items_sent--;
		end
	endtask

	// Track the base loosely from observed results, to keep acks in the window.
	always @(posedge clk)
		if (done)
			granted_lo <= base_seq;

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fill with reset window, tick nothing due, acks out of order.
		for (int i = 0; i < 9; i++)
			issue_item(MODE_SEND, '0, 32'(i * 10));
		issue_item(MODE_TICK, '0, 32'd100);
		issue_item(MODE_ACK, 31'd3, 32'd400);
		issue_item(MODE_ACK, 31'd3, 32'd500);
		issue_item(MODE_ACK, 31'd1, 32'd600);
		issue_item(MODE_ACK, 31'd2, 32'd700);
		issue_item(MODE_ACK, 31'd0, 32'hFFFF_FFFF);
		issue_item(MODE_ACK, 31'h7FFF_FFFF, 32'd0);
		issue_item(MODE_TICK, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		issue_item(MODE_NONE, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
		drain();

		// Window zero: every send refused; timeout zero makes any aged slot due.
		write_cfg(16'd0, 16'd0);
		issue_item(MODE_SEND, '0, 32'd5);
		issue_item(MODE_TICK, '0, 32'd6);
		drain();

		// Window above the slot count saturates; fill all slots, then a wide tick.
		write_cfg(16'd31, 16'd0);
		for (int i = 0; i < 12; i++)
			issue_item(MODE_SEND, '0, 32'd7);
		issue_item(MODE_TICK, '0, 32'd8);
		drain();

		clock_ms = 32'd1000;
		// Random phases over several window and timeout settings.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_cfg(16'd1, 16'd1);
				1: write_cfg(16'd16, 16'hFFFF);
				2: write_cfg(16'($urandom_range(2, 15)), 16'($urandom_range(500, 6000)));
				3: write_cfg(16'd8, 16'd5000);
				default: write_cfg(16'($urandom_range(0, 31)), 16'($urandom));
			endcase
			for (int k = 0; k < RANDOM_ITEMS / 5; k++) begin
				random_item();
				if (ph != 3)
					idle_gap();
			end
			drain();
		end

		$display("covered %0d items and %0d results over several window and timeout settings",
			items_sent, results_seen);
		if (fail_count == 0)
			$display("selective_repeat_send_window_top verification clean");
		else
			$display("selective_repeat_send_window_top verification failed");
		$finish;
	end
endmodule

>>> sim.f
rtl/core/srsw_pkg.sv
rtl/core/srsw_ctrl.sv
rtl/core/srsw_dp.sv
rtl/core/selective_repeat_send_window_top.sv
sim/srsw_checker.sv
sim/testbench.sv
